// ===== sv/rbei_pkg.sv =====
// ---------------------------------------------------------------------------
// Rigid body integrator package
// Shared word types, beat payload structs and the control group of the
// shared arithmetic unit.
// ---------------------------------------------------------------------------
package rbei_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;
    localparam int DT_BITS   = 16;
    localparam int INV_BITS  = 31;

    typedef logic signed [WORD_BITS-1:0] word_t;
    typedef word_t [2:0] vec_t;
    typedef logic [2:0] cmd_t;
    typedef logic [DT_BITS-1:0] dt_t;
    typedef logic [INV_BITS-1:0] inv_t;

    typedef struct packed {
        cmd_t  cmd;
        word_t vec_x;
        word_t vec_y;
        word_t vec_z;
        word_t point_x;
        word_t point_y;
        word_t point_z;
        word_t center_x;
        word_t center_y;
        word_t center_z;
        dt_t   dt;
    } in_t;

    typedef struct packed {
        word_t vel_x;
        word_t vel_y;
        word_t vel_z;
        word_t spin_x;
        word_t spin_y;
        word_t spin_z;
        word_t move_x;
        word_t move_y;
        word_t move_z;
        word_t turn_x;
        word_t turn_y;
        word_t turn_z;
    } out_t;

    // Control of the shared unit for one step.
    typedef struct packed {
        logic mul_en;    // capture a new product
        logic use_prod;  // add the scaled product instead of the plain operand
        logic sub;       // subtract instead of add
    } alu_ctl_t;

endpackage

// ===== sv/rbei_alu.sv =====
// ---------------------------------------------------------------------------
// Rigid body integrator shared arithmetic unit
// One signed multiplier with a product register, followed by a floor shift,
// saturation and a saturating add or subtract.
// ---------------------------------------------------------------------------
module rbei_alu
    import rbei_pkg::*;
(
    input  logic     clk,
    input  alu_ctl_t ctl,
    input  word_t    mul_a,
    input  word_t    mul_b,
    input  word_t    add_a,
    input  word_t    add_b,
    output word_t    result
);

    localparam int PROD_BITS = 2 * WORD_BITS;
    localparam int Q_BITS    = PROD_BITS - FRAC_BITS;

    logic signed [PROD_BITS-1:0] prod_reg;
    logic signed [PROD_BITS-1:0] prod_next;
    logic [Q_BITS-1:0]           q;
    logic [Q_BITS-WORD_BITS:0]   q_top;
    word_t                       scaled;
    word_t                       addend;
    logic [WORD_BITS:0]          sum;

    always_comb
    begin
        prod_next = ctl.mul_en ? mul_a * mul_b : prod_reg;
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    // Dropping the low bits of a two's complement product rounds toward
    // minus infinity.
    always_comb
    begin
        q     = prod_reg[PROD_BITS-1:FRAC_BITS];
        q_top = q[Q_BITS-1:WORD_BITS-1];
        if (q_top == '0 || q_top == '1)
        begin
            scaled = word_t'(q[WORD_BITS-1:0]);
        end
        else if (q[Q_BITS-1])
        begin
            scaled = {1'b1, {(WORD_BITS-1){1'b0}}};
        end
        else
        begin
            scaled = {1'b0, {(WORD_BITS-1){1'b1}}};
        end
    end

    always_comb
    begin
        addend = ctl.use_prod ? scaled : add_b;
        if (ctl.sub)
        begin
            sum = {add_a[WORD_BITS-1], add_a} - {addend[WORD_BITS-1], addend};
        end
        else
        begin
            sum = {add_a[WORD_BITS-1], add_a} + {addend[WORD_BITS-1], addend};
        end
        if (sum[WORD_BITS] != sum[WORD_BITS-1])
        begin
            result = sum[WORD_BITS] ? {1'b1, {(WORD_BITS-1){1'b0}}}
                                    : {1'b0, {(WORD_BITS-1){1'b1}}};
        end
        else
        begin
            result = word_t'(sum[WORD_BITS-1:0]);
        end
    end

endmodule

// ===== sv/rigid_body_euler_integrator_unit.sv =====
// ---------------------------------------------------------------------------
// Rigid body Euler integrator
// Accumulates force and torque for one body and advances its linear and
// angular velocity with a semi-implicit Euler tick, in saturating Q16.16.
// ---------------------------------------------------------------------------
// Usage. Each input beat carries one command (add force, add force at a
// point, add torque, clear, tick) and returns exactly one output beat with the
// velocity and spin after the command, plus move and turn on a moving tick.
// Configuration beats (inverse mass, inverse moment, gravity enable, static
// flag, gravity vector) are taken in any cycle and must only be sent while the
// block is idle. Register indexes beyond the list are ignored.
// Each input beat is worked by the sequencer driving the single shared multiply
// and saturating add unit; the result is then loaded into the output register.
// The block takes one item at a time; in_ready is high whenever no item is in
// work, including while a finished beat waits in the output register.
// With an open receiver the block returns to idle as the result is loaded and
// can take the next beat there.
// If the receiver stalls, a completed item waits in the sequencer until the
// output register frees, and no further input beat is accepted meanwhile.
// Reset clears the sums, velocities and spin and restores the register
// defaults (unit reciprocals, gravity on at -9.81 along y, body not static).
// ---------------------------------------------------------------------------
module rigid_body_euler_integrator_unit
    import rbei_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  in_t        in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output out_t       out_data,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [2:0] cfg_index,
    input  word_t      cfg_data
);

    localparam cmd_t CMD_ADD_FORCE  = 3'd0;
    localparam cmd_t CMD_FORCE_AT   = 3'd1;
    localparam cmd_t CMD_ADD_TORQUE = 3'd2;
    localparam cmd_t CMD_CLEAR      = 3'd3;
    localparam cmd_t CMD_TICK       = 3'd4;

    localparam logic [2:0] CFG_INV_MASS   = 3'd0;
    localparam logic [2:0] CFG_INV_MOMENT = 3'd1;
    localparam logic [2:0] CFG_GRAVITY_ON = 3'd2;
    localparam logic [2:0] CFG_HOLD_STILL = 3'd3;
    localparam logic [2:0] CFG_GRAVITY_X  = 3'd4;
    localparam logic [2:0] CFG_GRAVITY_Y  = 3'd5;
    localparam logic [2:0] CFG_GRAVITY_Z  = 3'd6;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    localparam logic [3:0] DST_NONE   = 4'd0;
    localparam logic [3:0] DST_FORCE  = 4'd1;
    localparam logic [3:0] DST_TORQUE = 4'd2;
    localparam logic [3:0] DST_VEL    = 4'd3;
    localparam logic [3:0] DST_SPIN   = 4'd4;
    localparam logic [3:0] DST_MOVE   = 4'd5;
    localparam logic [3:0] DST_TURN   = 4'd6;
    localparam logic [3:0] DST_R      = 4'd7;
    localparam logic [3:0] DST_TMP    = 4'd8;

    localparam inv_t  UNIT_INV  = inv_t'(1 << FRAC_BITS);
    localparam word_t GRAV_Y_RST = -32'sd642908;

    // Rotate a vector by one axis: element 0 takes what element 1 held.
    function automatic vec_t rot(input vec_t v);
        rot = {v[0], v[2], v[1]};
    endfunction

    // Sequencer and configuration state.
    logic [1:0] state_reg, state_next;
    logic [3:0] phase_reg, phase_next;
    logic [1:0] axis_reg, axis_next;
    logic       pass_reg, pass_next;
    cmd_t       cmd_reg, cmd_next;
    logic       out_valid_reg, out_valid_next;
    inv_t       inv_mass_reg, inv_mass_next;
    inv_t       inv_moment_reg, inv_moment_next;
    logic       gravity_on_reg, gravity_on_next;
    logic       hold_still_reg, hold_still_next;
    word_t      grav_x_reg, grav_x_next;
    word_t      grav_y_reg, grav_y_next;
    word_t      grav_z_reg, grav_z_next;

    // Body state.
    vec_t       force_reg, force_next;
    vec_t       torque_reg, torque_next;
    vec_t       vel_reg, vel_next;
    vec_t       spin_reg, spin_next;
    vec_t       move_reg, move_next;
    vec_t       turn_reg, turn_next;

    // Item payload and scratch.
    vec_t       f_reg, f_next;
    vec_t       p_reg, p_next;
    vec_t       c_reg, c_next;
    vec_t       r_reg, r_next;
    vec_t       g_reg, g_next;
    word_t      tmp_reg, tmp_next;
    dt_t        dt_reg, dt_next;
    out_t       out_data_reg, out_data_next;

    // Step decode.
    alu_ctl_t   alu_ctl;
    word_t      mul_a;
    word_t      mul_b;
    word_t      add_a;
    word_t      add_b;
    word_t      alu_result;
    logic [3:0] dst;
    logic       last_phase;
    logic       one_shot;
    logic       run;
    logic       axis_end;
    logic       item_done;
    word_t      dt_word;
    word_t      inv_mass_word;
    word_t      inv_moment_word;

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign dt_word         = word_t'({{(WORD_BITS-DT_BITS){1'b0}}, dt_reg});
    assign inv_mass_word   = word_t'({1'b0, inv_mass_reg});
    assign inv_moment_word = word_t'({1'b0, inv_moment_reg});

    rbei_alu u_alu (
        .clk    (clk),
        .ctl    (alu_ctl),
        .mul_a  (mul_a),
        .mul_b  (mul_b),
        .add_a  (add_a),
        .add_b  (add_b),
        .result (alu_result)
    );

    // Every step works on element 0 of the vectors. At the end of an axis all
    // vectors rotate, so after three axes they are back in place. The cross
    // product term for element 0 is r[1]*f[2] - r[2]*f[1].
    always_comb
    begin
        alu_ctl    = '0;
        mul_a      = f_reg[0];
        mul_b      = f_reg[0];
        add_a      = f_reg[0];
        add_b      = f_reg[0];
        dst        = DST_NONE;
        last_phase = 1'b1;
        one_shot   = 1'b0;
        unique case (cmd_reg)
            CMD_ADD_FORCE:
            begin
                add_a = force_reg[0];
                dst   = DST_FORCE;
            end
            CMD_ADD_TORQUE:
            begin
                add_a = torque_reg[0];
                dst   = DST_TORQUE;
            end
            CMD_FORCE_AT:
            begin
                if (!pass_reg)
                begin
                    // First pass: sum the force and form the lever arm.
                    if (phase_reg == 4'd0)
                    begin
                        add_a      = force_reg[0];
                        dst        = DST_FORCE;
                        last_phase = 1'b0;
                    end
                    else
                    begin
                        add_a       = p_reg[0];
                        add_b       = c_reg[0];
                        alu_ctl.sub = 1'b1;
                        dst         = DST_R;
                    end
                end
                else
                begin
                    last_phase = 1'b0;
                    unique case (phase_reg)
                        4'd0:
                        begin
                            mul_a          = r_reg[1];
                            mul_b          = f_reg[2];
                            alu_ctl.mul_en = 1'b1;
                        end
                        4'd1:
                        begin
                            add_a            = '0;
                            alu_ctl.use_prod = 1'b1;
                            dst              = DST_TMP;
                        end
                        4'd2:
                        begin
                            mul_a          = r_reg[2];
                            mul_b          = f_reg[1];
                            alu_ctl.mul_en = 1'b1;
                        end
                        4'd3:
                        begin
                            add_a            = tmp_reg;
                            alu_ctl.use_prod = 1'b1;
                            alu_ctl.sub      = 1'b1;
                            dst              = DST_TMP;
                        end
                        4'd4:
                        begin
                            add_a      = torque_reg[0];
                            add_b      = tmp_reg;
                            dst        = DST_TORQUE;
                            last_phase = 1'b1;
                        end
                        default:
                        begin
                            last_phase = 1'b1;
                        end
                    endcase
                end
            end
            CMD_TICK:
            begin
                if (hold_still_reg)
                begin
                    one_shot = 1'b1;
                end
                else
                begin
                    last_phase = 1'b0;
                    unique case (phase_reg)
                        4'd0:
                        begin
                            mul_a          = force_reg[0];
                            mul_b          = inv_mass_word;
                            alu_ctl.mul_en = 1'b1;
                        end
                        4'd1:
                        begin
                            // Acceleration plus gravity (zero when disabled).
                            add_a            = g_reg[0];
                            alu_ctl.use_prod = 1'b1;
                            dst              = DST_TMP;
                        end
                        4'd2:
                        begin
                            mul_a          = tmp_reg;
                            mul_b          = dt_word;
                            alu_ctl.mul_en = 1'b1;
                        end
                        4'd3:
                        begin
                            add_a            = vel_reg[0];
                            alu_ctl.use_prod = 1'b1;
                            dst              = DST_VEL;
                        end
                        4'd4:
                        begin
                            mul_a          = vel_reg[0];
                            mul_b          = dt_word;
                            alu_ctl.mul_en = 1'b1;
                        end
                        4'd5:
                        begin
                            add_a            = '0;
                            alu_ctl.use_prod = 1'b1;
                            dst              = DST_MOVE;
                        end
                        4'd6:
                        begin
                            mul_a          = torque_reg[0];
                            mul_b          = inv_moment_word;
                            alu_ctl.mul_en = 1'b1;
                        end
                        4'd7:
                        begin
                            add_a            = '0;
                            alu_ctl.use_prod = 1'b1;
                            dst              = DST_TMP;
                        end
                        4'd8:
                        begin
                            mul_a          = tmp_reg;
                            mul_b          = dt_word;
                            alu_ctl.mul_en = 1'b1;
                        end
                        4'd9:
                        begin
                            add_a            = spin_reg[0];
                            alu_ctl.use_prod = 1'b1;
                            dst              = DST_SPIN;
                        end
                        4'd10:
                        begin
                            mul_a          = spin_reg[0];
                            mul_b          = dt_word;
                            alu_ctl.mul_en = 1'b1;
                        end
                        4'd11:
                        begin
                            add_a            = '0;
                            alu_ctl.use_prod = 1'b1;
                            dst              = DST_TURN;
                            last_phase       = 1'b1;
                        end
                        default:
                        begin
                            last_phase = 1'b1;
                        end
                    endcase
                end
            end
            default:
            begin
                // Clear and the unused commands finish in a single step.
                one_shot = 1'b1;
            end
        endcase
    end

    assign run       = (state_reg == ST_RUN);
    assign axis_end  = run && last_phase && !one_shot;
    assign item_done = run && (one_shot || (last_phase && axis_reg == 2'd2 &&
                       (cmd_reg != CMD_FORCE_AT || pass_reg)));

    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        axis_next       = axis_reg;
        pass_next       = pass_reg;
        cmd_next        = cmd_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_data_next   = out_data_reg;
        inv_mass_next   = inv_mass_reg;
        inv_moment_next = inv_moment_reg;
        gravity_on_next = gravity_on_reg;
        hold_still_next = hold_still_reg;
        grav_x_next     = grav_x_reg;
        grav_y_next     = grav_y_reg;
        grav_z_next     = grav_z_reg;
        force_next      = force_reg;
        torque_next     = torque_reg;
        vel_next        = vel_reg;
        spin_next       = spin_reg;
        move_next       = move_reg;
        turn_next       = turn_reg;
        f_next          = f_reg;
        p_next          = p_reg;
        c_next          = c_reg;
        r_next          = r_reg;
        g_next          = g_reg;
        tmp_next        = tmp_reg;
        dt_next         = dt_reg;

        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_INV_MASS:   inv_mass_next   = cfg_data[INV_BITS-1:0];
                CFG_INV_MOMENT: inv_moment_next = cfg_data[INV_BITS-1:0];
                CFG_GRAVITY_ON: gravity_on_next = cfg_data[0];
                CFG_HOLD_STILL: hold_still_next = cfg_data[0];
                CFG_GRAVITY_X:  grav_x_next     = cfg_data;
                CFG_GRAVITY_Y:  grav_y_next     = cfg_data;
                CFG_GRAVITY_Z:  grav_z_next     = cfg_data;
                default:
                begin
                end
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next   = in_data.cmd;
                    dt_next    = in_data.dt;
                    f_next     = {in_data.vec_z, in_data.vec_y, in_data.vec_x};
                    p_next     = {in_data.point_z, in_data.point_y, in_data.point_x};
                    c_next     = {in_data.center_z, in_data.center_y, in_data.center_x};
                    g_next     = gravity_on_reg ? {grav_z_reg, grav_y_reg, grav_x_reg}
                                                : '0;
                    move_next  = '0;
                    turn_next  = '0;
                    phase_next = '0;
                    axis_next  = '0;
                    pass_next  = 1'b0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                unique case (dst)
                    DST_FORCE:  force_next[0]  = alu_result;
                    DST_TORQUE: torque_next[0] = alu_result;
                    DST_VEL:    vel_next[0]    = alu_result;
                    DST_SPIN:   spin_next[0]   = alu_result;
                    DST_MOVE:   move_next[0]   = alu_result;
                    DST_TURN:   turn_next[0]   = alu_result;
                    DST_R:      r_next[0]      = alu_result;
                    DST_TMP:    tmp_next       = alu_result;
                    default:
                    begin
                    end
                endcase

                phase_next = last_phase ? 4'd0 : phase_reg + 4'd1;

                if (axis_end)
                begin
                    force_next  = rot(force_next);
                    torque_next = rot(torque_next);
                    vel_next    = rot(vel_next);
                    spin_next   = rot(spin_next);
                    move_next   = rot(move_next);
                    turn_next   = rot(turn_next);
                    f_next      = rot(f_next);
                    p_next      = rot(p_next);
                    c_next      = rot(c_next);
                    r_next      = rot(r_next);
                    g_next      = rot(g_next);
                    if (axis_reg == 2'd2)
                    begin
                        axis_next = 2'd0;
                        pass_next = 1'b1;
                    end
                    else
                    begin
                        axis_next = axis_reg + 2'd1;
                    end
                end

                if (item_done)
                begin
                    // Clear and every tick, moving or static, empty the sums.
                    if (cmd_reg == CMD_CLEAR || cmd_reg == CMD_TICK)
                    begin
                        force_next  = '0;
                        torque_next = '0;
                    end
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_data_next.vel_x  = vel_reg[0];
                    out_data_next.vel_y  = vel_reg[1];
                    out_data_next.vel_z  = vel_reg[2];
                    out_data_next.spin_x = spin_reg[0];
                    out_data_next.spin_y = spin_reg[1];
                    out_data_next.spin_z = spin_reg[2];
                    out_data_next.move_x = move_reg[0];
                    out_data_next.move_y = move_reg[1];
                    out_data_next.move_z = move_reg[2];
                    out_data_next.turn_x = turn_reg[0];
                    out_data_next.turn_y = turn_reg[1];
                    out_data_next.turn_z = turn_reg[2];
                    out_valid_next       = 1'b1;
                    state_next           = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control, configuration and body state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            phase_reg      <= '0;
            axis_reg       <= '0;
            pass_reg       <= 1'b0;
            cmd_reg        <= CMD_CLEAR;
            out_valid_reg  <= 1'b0;
            inv_mass_reg   <= UNIT_INV;
            inv_moment_reg <= UNIT_INV;
            gravity_on_reg <= 1'b1;
            hold_still_reg <= 1'b0;
            grav_x_reg     <= '0;
            grav_y_reg     <= GRAV_Y_RST;
            grav_z_reg     <= '0;
            force_reg      <= '0;
            torque_reg     <= '0;
            vel_reg        <= '0;
            spin_reg       <= '0;
            move_reg       <= '0;
            turn_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            axis_reg       <= axis_next;
            pass_reg       <= pass_next;
            cmd_reg        <= cmd_next;
            out_valid_reg  <= out_valid_next;
            inv_mass_reg   <= inv_mass_next;
            inv_moment_reg <= inv_moment_next;
            gravity_on_reg <= gravity_on_next;
            hold_still_reg <= hold_still_next;
            grav_x_reg     <= grav_x_next;
            grav_y_reg     <= grav_y_next;
            grav_z_reg     <= grav_z_next;
            force_reg      <= force_next;
            torque_reg     <= torque_next;
            vel_reg        <= vel_next;
            spin_reg       <= spin_next;
            move_reg       <= move_next;
            turn_reg       <= turn_next;
        end
    end

    // Item payload and scratch.
    always_ff @(posedge clk)
    begin
        f_reg        <= f_next;
        p_reg        <= p_next;
        c_reg        <= c_next;
        r_reg        <= r_next;
        g_reg        <= g_next;
        tmp_reg      <= tmp_next;
        dt_reg       <= dt_next;
        out_data_reg <= out_data_next;
    end

endmodule
